// ----- sv/srarq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the selective-repeat ARQ sender: sizes, reset values, codes and shared types.
// Depends on nothing; every other file but srarq_slot_if refers to it by scoped names.
package srarq_pkg;

    localparam int MaxPackets = 16;
    localparam int MaxWindow  = 8;
    localparam int SeqW       = $clog2(MaxPackets);
    localparam int CntW       = 5;
    localparam int WinW       = 4;
    localparam int RoundW     = 3;

    localparam logic [CntW-1:0]   ResetTotal  = 5'd10;
    localparam logic [WinW-1:0]   ResetWindow = 4'd4;
    localparam logic [CntW-1:0]   TotalMax    = CntW'(MaxPackets);
    localparam logic [WinW-1:0]   WindowMax   = WinW'(MaxWindow);
    localparam logic [RoundW-1:0] RoundLimit  = 3'd4;

    typedef enum logic [0:0] {
        CFG_TOTAL  = 1'b0,
        CFG_WINDOW = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_SLIDE,
        ST_SCAN,
        ST_RECV,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic in_total;
        logic in_window;
        logic acked;
    } probe_t;

    typedef struct packed {
        logic            sent_valid;
        logic [SeqW-1:0] sent_seq;
        logic            is_retransmit;
        logic [CntW-1:0] window_base;
        logic [CntW-1:0] receiver_next;
        logic            all_done;
    } result_t;

endpackage

// ----- sv/srarq_slot_if.sv -----
`timescale 1ns / 1ps
// Input channel of the ARQ sender: one word per transmission slot.
// Depends on nothing.
interface srarq_slot_if;
    logic valid;
    logic ready;
    logic delivered;

    modport source (output valid, output delivered, input ready);
    modport sink (input valid, input delivered, output ready);
endinterface

// ----- sv/srarq_report_if.sv -----
`timescale 1ns / 1ps
// Output channel of the ARQ sender: one report word per transmission slot.
// Depends on srarq_pkg for the field widths.
interface srarq_report_if;
    logic                          valid;
    logic                          ready;
    logic                          sent_valid;
    logic [srarq_pkg::SeqW-1:0]    sent_seq;
    logic                          is_retransmit;
    logic [srarq_pkg::CntW-1:0]    window_base;
    logic [srarq_pkg::CntW-1:0]    receiver_next;
    logic                          all_done;

    modport source (output valid, output sent_valid, output sent_seq, output is_retransmit,
                    output window_base, output receiver_next, output all_done, input ready);
    modport sink (input valid, input sent_valid, input sent_seq, input is_retransmit,
                  input window_base, input receiver_next, input all_done, output ready);
endinterface

// ----- sv/selective_repeat_arq_sender_core.sv -----
`timescale 1ns / 1ps
// Selective-repeat ARQ sender with its receiver; depends on srarq_pkg, srarq_slot_if,
// srarq_report_if, srarq_probe and srarq_seq. From acceptance of a word to its report word,
// the shared probe tests one packet position per cycle while the base slides,
// the window is scanned and the receiver advances. Reports leave through an output register;
// the next word is accepted once the report is loaded, not before.
// Reset clears the bitmap and all pointers but the scan index at once and loads total 10, window 4.
module selective_repeat_arq_sender_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    srarq_slot_if.sink                 slot,
    srarq_report_if.source             report,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [srarq_pkg::CntW-1:0] cfg_data
);

    logic [srarq_pkg::CntW-1:0] total_reg;
    logic [srarq_pkg::WinW-1:0] window_reg;
    logic [srarq_pkg::CntW-1:0] total_eff;
    logic [srarq_pkg::WinW-1:0] window_eff;
    logic                       out_valid_reg;
    srarq_pkg::result_t         out_reg;
    srarq_pkg::result_t         result;
    logic                       out_free;
    logic                       res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= srarq_pkg::ResetTotal;
            window_reg <= srarq_pkg::ResetWindow;
        end
        else if (cfg_we)
        begin
            if (cfg_index == srarq_pkg::CFG_TOTAL)
            begin
                total_reg <= cfg_data;
            end
            else
            begin
                window_reg <= cfg_data[srarq_pkg::WinW-1:0];
            end
        end
    end

    // Out-of-range settings are clamped to the supported session and window sizes.
    assign total_eff  = (total_reg > srarq_pkg::TotalMax) ? srarq_pkg::TotalMax : total_reg;
    assign window_eff = (window_reg == '0) ? srarq_pkg::WinW'(1) :
                        (window_reg > srarq_pkg::WindowMax) ? srarq_pkg::WindowMax : window_reg;

    assign out_free = !out_valid_reg || report.ready;

    srarq_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (slot.valid),
        .in_ready     (slot.ready),
        .in_delivered (slot.delivered),
        .total        (total_eff),
        .win          (window_eff),
        .out_free     (out_free),
        .res_load     (res_load),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= result;
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.sent_valid    = out_reg.sent_valid;
    assign report.sent_seq      = out_reg.sent_seq;
    assign report.is_retransmit = out_reg.is_retransmit;
    assign report.window_base   = out_reg.window_base;
    assign report.receiver_next = out_reg.receiver_next;
    assign report.all_done      = out_reg.all_done;

endmodule

// ----- sv/srarq_probe.sv -----
`timescale 1ns / 1ps
// Shared probe unit: tests one packet number against the total, the window and the bitmap.
// Depends on srarq_pkg.
module srarq_probe
(
    input  logic [srarq_pkg::CntW-1:0]       pos,
    input  logic [srarq_pkg::CntW-1:0]       base,
    input  logic [srarq_pkg::WinW-1:0]       win,
    input  logic [srarq_pkg::CntW-1:0]       total,
    input  logic [srarq_pkg::MaxPackets-1:0] ack_map,
    output srarq_pkg::probe_t                probe
);

    logic [srarq_pkg::CntW:0] win_end;

    assign win_end         = {1'b0, base} + (srarq_pkg::CntW+1)'(win);
    assign probe.in_total  = pos < total;
    assign probe.in_window = {1'b0, pos} < win_end;
    assign probe.acked     = probe.in_total && ack_map[pos[srarq_pkg::SeqW-1:0]];

endmodule

// ----- sv/srarq_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the ARQ sender: walks the send, slide, scan and receive steps one
// packet position per cycle through the shared probe. Depends on srarq_pkg and srarq_probe.
module srarq_seq
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_delivered,
    input  logic [srarq_pkg::CntW-1:0] total,
    input  logic [srarq_pkg::WinW-1:0] win,
    input  logic                       out_free,
    output logic                       res_load,
    output srarq_pkg::result_t         result
);

    srarq_pkg::seq_state_t            state_reg, state_next;
    logic [srarq_pkg::CntW-1:0]       base_reg, base_next;
    logic [srarq_pkg::CntW-1:0]       new_reg, new_next;
    logic [srarq_pkg::MaxPackets-1:0] map_reg, map_next;
    logic [srarq_pkg::CntW-1:0]       recv_reg, recv_next;
    logic                             retx_phase_reg, retx_phase_next;
    logic [srarq_pkg::CntW-1:0]       scan_reg, scan_next;
    logic [srarq_pkg::CntW-1:0]       idx_reg, idx_next;
    logic [srarq_pkg::RoundW-1:0]     round_reg, round_next;
    logic                             sent_reg, sent_next;
    logic                             retx_reg, retx_next;
    logic [srarq_pkg::SeqW-1:0]       seq_reg, seq_next;
    logic                             ok_reg, ok_next;
    logic [srarq_pkg::CntW-1:0]       pos;
    srarq_pkg::probe_t                probe;
    logic                             finished;

    srarq_probe u_probe
    (
        .pos     (pos),
        .base    (base_reg),
        .win     (win),
        .total   (total),
        .ack_map (map_reg),
        .probe   (probe)
    );

    assign finished = base_reg >= total;

    assign result.sent_valid    = sent_reg;
    assign result.sent_seq      = seq_reg;
    assign result.is_retransmit = retx_reg;
    assign result.window_base   = base_reg;
    assign result.receiver_next = recv_reg;
    assign result.all_done      = finished;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srarq_pkg::ST_IDLE;
            base_reg       <= '0;
            new_reg        <= '0;
            map_reg        <= '0;
            recv_reg       <= '0;
            retx_phase_reg <= 1'b0;
            scan_reg       <= '0;
            round_reg      <= '0;
            sent_reg       <= 1'b0;
            retx_reg       <= 1'b0;
            seq_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            new_reg        <= new_next;
            map_reg        <= map_next;
            recv_reg       <= recv_next;
            retx_phase_reg <= retx_phase_next;
            scan_reg       <= scan_next;
            round_reg      <= round_next;
            sent_reg       <= sent_next;
            retx_reg       <= retx_next;
            seq_reg        <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ok_reg  <= ok_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        new_next        = new_reg;
        map_next        = map_reg;
        recv_next       = recv_reg;
        retx_phase_next = retx_phase_reg;
        scan_next       = scan_reg;
        idx_next        = idx_reg;
        round_next      = round_reg;
        sent_next       = sent_reg;
        retx_next       = retx_reg;
        seq_next        = seq_reg;
        ok_next         = ok_reg;
        in_ready        = 1'b0;
        res_load        = 1'b0;
        pos             = new_reg;

        unique case (state_reg)
            srarq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ok_next    = in_delivered;
                    round_next = '0;
                    sent_next  = 1'b0;
                    retx_next  = 1'b0;
                    seq_next   = '0;
                    state_next = srarq_pkg::ST_ROUND;
                end
            end
            srarq_pkg::ST_ROUND:
            begin
                pos = new_reg;
                if (round_reg == srarq_pkg::RoundLimit || finished)
                begin
                    state_next = srarq_pkg::ST_FINISH;
                end
                else if (!retx_phase_reg)
                begin
                    if (probe.in_total && probe.in_window)
                    begin
                        seq_next  = new_reg[srarq_pkg::SeqW-1:0];
                        new_next  = new_reg + srarq_pkg::CntW'(1);
                        sent_next = 1'b1;
                        if (ok_reg)
                        begin
                            map_next[new_reg[srarq_pkg::SeqW-1:0]] = 1'b1;
                            state_next = srarq_pkg::ST_RECV;
                        end
                        else
                        begin
                            state_next = srarq_pkg::ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = srarq_pkg::ST_SLIDE;
                    end
                end
                else
                begin
                    idx_next   = scan_reg;
                    state_next = srarq_pkg::ST_SCAN;
                end
            end
            srarq_pkg::ST_SLIDE:
            begin
                pos = base_reg;
                if (probe.acked)
                begin
                    base_next = base_reg + srarq_pkg::CntW'(1);
                end
                else
                begin
                    retx_phase_next = 1'b1;
                    scan_next       = base_reg;
                    round_next      = round_reg + srarq_pkg::RoundW'(1);
                    state_next      = srarq_pkg::ST_ROUND;
                end
            end
            srarq_pkg::ST_SCAN:
            begin
                pos = idx_reg;
                if (probe.in_total && probe.in_window && probe.acked)
                begin
                    idx_next = idx_reg + srarq_pkg::CntW'(1);
                end
                else if (probe.in_total && probe.in_window)
                begin
                    seq_next  = idx_reg[srarq_pkg::SeqW-1:0];
                    scan_next = idx_reg + srarq_pkg::CntW'(1);
                    sent_next = 1'b1;
                    retx_next = 1'b1;
                    if (ok_reg)
                    begin
                        map_next[idx_reg[srarq_pkg::SeqW-1:0]] = 1'b1;
                        state_next = srarq_pkg::ST_RECV;
                    end
                    else
                    begin
                        state_next = srarq_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    retx_phase_next = 1'b0;
                    round_next      = round_reg + srarq_pkg::RoundW'(1);
                    state_next      = srarq_pkg::ST_ROUND;
                end
            end
            srarq_pkg::ST_RECV:
            begin
                pos = recv_reg;
                if (probe.acked)
                begin
                    recv_next = recv_reg + srarq_pkg::CntW'(1);
                end
                else
                begin
                    state_next = srarq_pkg::ST_FINISH;
                end
            end
            srarq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = srarq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srarq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
